[sv/frm_pkg.sv]
`timescale 1ns / 1ps
package frm_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_STORE,
    S_REQ,
    S_MEAN,
    S_AVG,
    S_MUL,
    S_SAT,
    S_RATE,
    S_TMO
  } frm_state_t;

  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_RATE = 1'b1;

  localparam logic [1:0] REG_CAL      = 2'd0;
  localparam logic [1:0] REG_MIN_PER  = 2'd1;
  localparam logic [1:0] REG_NO_FLOW  = 2'd2;
  localparam logic [1:0] REG_IDLE_MAX = 2'd3;

  localparam logic [31:0] CAL_RST      = 32'd65536;
  localparam logic [19:0] MIN_PER_RST  = 20'd250;
  localparam logic [15:0] NO_FLOW_RST  = 16'd4000;
  localparam logic [19:0] IDLE_MAX_RST = 20'd500000;
  localparam logic [31:0] MAX_PER_RST  = 32'd50000;

  // blend divisor: avg = (4*mean + avg + 2) / 5
  localparam logic [2:0] AVG_DIV = 3'd5;

  // floor(x / 5) = (x * AVG_RECIP) >> AVG_RECIP_SH for x < 2^34
  localparam logic [31:0] AVG_RECIP    = 32'hCCCCCCCD;
  localparam int          AVG_RECIP_SH = 34;

  // 60e6 * 2^40 as the rate dividend
  localparam int                      RATE_NUM_W     = 66;
  localparam logic [RATE_NUM_W-1:0]   RATE_NUM       = RATE_NUM_W'(64'd60000000) << 40;
  localparam logic [63:0]             RATE_SAT_LIMIT = 64'd15360000000;

endpackage

[sv/frm_div.sv]
`timescale 1ns / 1ps
module frm_div #(
  parameter int NUM_W = 66,
  parameter int DEN_W = 60
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [NUM_W-1:0]             num_i,
  input  logic [DEN_W-1:0]             den_i,
  input  logic [$clog2(NUM_W+1)-1:0]   steps_i,
  output logic [NUM_W-1:0]             quo_o,
  output logic                         done_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // restoring step: dividend shifts out MSB first, quotient shifts in at LSB
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= steps_i;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

  assign quo_o  = num_r;
  assign done_o = done_r;

endmodule

[sv/frm_ring.sv]
`timescale 1ns / 1ps
module frm_ring #(
  parameter int RING_DEPTH  = 24,
  parameter int PERIOD_BITS = 20
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               wr_en,
  input  logic                                               clr,
  input  logic [PERIOD_BITS-1:0]                             din,
  output logic [PERIOD_BITS+$clog2(RING_DEPTH+1)-1:0]        sum_o,
  output logic [$clog2(RING_DEPTH+1)-1:0]                    fill_o
);

  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = PERIOD_BITS + FILL_W;
  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic [PERIOD_BITS-1:0] mem [RING_DEPTH];
  logic [PERIOD_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]       idx_r;
  logic [FILL_W-1:0]      fill_r;
  logic [SUM_W-1:0]       sum_r;

  logic [PERIOD_BITS-1:0] old_val;
  logic [SUM_W-1:0]       sum_nxt;
  logic [IDX_W-1:0]       idx_nxt;

  // entries at or past the fill count were never written since the last clear
  assign old_val = (FILL_W'(idx_r) < fill_r) ? rd_data_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(din);
  assign idx_nxt = (idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= din;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (clr) begin
      idx_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (wr_en) begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      if (fill_r != FILL_W'(RING_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign sum_o  = sum_r;
  assign fill_o = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(RING_DEPTH))
    else $error("ring fill past depth");

  a_wr_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && clr))
    else $error("ring write and clear together");

endmodule

[sv/flow_pulse_rate_meter.sv]
`timescale 1ns / 1ps
// Pin sample beat: S_EDGE, then S_STORE loads the result once the output is free and returns to idle.
// Rate request beat: ring mean division, blend, multiply and saturation check, then rate division on
//   the shared restoring divider (one quotient bit a cycle) used for the ring mean and the rate;
//   a saturated rate skips the rate division, a request with no update or an empty ring skips both.
// Input is accepted in idle while an earlier result still waits in the output register.
// Reset (rst_n, synchronous, active low) loads register defaults and clears the meter state;
//   ring contents are masked by the fill count, so no clearing pass is needed.
module flow_pulse_rate_meter #(
  parameter int RING_DEPTH  = 24,
  parameter int PERIOD_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic        in_pin_level,
  input  logic [31:0] in_time_us,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rate_upm,
  output logic [31:0] out_total_pulses,
  output logic        out_edge_accepted,
  output logic        out_period_stored,
  output logic        out_no_flow
);

  localparam int AVG_W      = PERIOD_BITS + 8;
  localparam int BLEND_W    = AVG_W + 3;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = PERIOD_BITS + FILL_W;
  localparam int MEAN_STEPS = SUM_W + 8;
  localparam int NUM_W      = (MEAN_STEPS > frm_pkg::RATE_NUM_W) ? MEAN_STEPS
                                                                 : frm_pkg::RATE_NUM_W;
  localparam int DEN_W      = AVG_W + 32;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam logic [31:0] PMASK32 = 32'((64'd1 << PERIOD_BITS) - 64'd1);

  frm_pkg::frm_state_t state_r, state_nxt;

  logic [31:0]            cal_r;
  logic [19:0]            minp_r;
  logic [15:0]            noflow_r;
  logic [19:0]            idle_r;

  logic                   prev_r;
  logic [31:0]            last_edge_r;
  logic [31:0]            pending_r;
  logic [AVG_W-1:0]       avg_r;
  logic [PERIOD_BITS-1:0] maxp_r;
  logic [31:0]            last_pulse_r;
  logic [31:0]            rate_r;
  logic [31:0]            total_r;

  logic                   lvl_r;
  logic [31:0]            t_us_r;
  logic [31:0]            t_ms_r;
  logic                   acc_r;
  logic                   sto_r;
  logic [PERIOD_BITS-1:0] dur_r;
  logic [DEN_W-1:0]       prod_r;
  logic [BLEND_W-1:0]     blend_r;

  logic                   out_valid_r;
  logic [31:0]            out_rate_r;
  logic [31:0]            out_total_r;
  logic                   out_acc_r;
  logic                   out_sto_r;
  logic                   out_nf_r;

  logic                   ring_wr;
  logic                   ring_clr;
  logic [SUM_W-1:0]       ring_sum;
  logic [FILL_W-1:0]      ring_fill;

  logic                   div_start;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic [CNT_W-1:0]       div_steps;
  logic [NUM_W-1:0]       div_q;
  logic                   div_done;

  logic                   out_free;
  logic                   out_load;
  logic [31:0]            dur;
  logic                   edge_acc;
  logic                   edge_sto;
  logic                   upd;
  logic [BLEND_W-1:0]     avg_num;
  logic [BLEND_W+31:0]    blend_p;
  logic [AVG_W+1:0]       mp3;
  logic [PERIOD_BITS-1:0] mp_sat;
  logic [PERIOD_BITS-1:0] idle_sat;
  logic [31:0]            elapsed;
  logic                   tmo;
  logic                   sat_hit;

  assign out_free = !out_valid_r || !out_stall;
  assign dur      = t_us_r - last_edge_r;
  assign edge_acc = (lvl_r != prev_r) && lvl_r && (dur > 32'(minp_r));
  assign edge_sto = edge_acc && (dur < 32'(maxp_r));
  assign upd      = (pending_r != '0) && (cal_r != '0);
  assign avg_num  = (BLEND_W'(div_q[AVG_W-1:0]) << 2) + BLEND_W'(avg_r)
                    + BLEND_W'(2'd2);
  assign blend_p  = (BLEND_W+32)'(blend_r) * (BLEND_W+32)'(frm_pkg::AVG_RECIP);
  assign mp3      = (AVG_W+2)'({avg_r, 1'b0}) + (AVG_W+2)'(avg_r);
  assign mp_sat   = mp3[AVG_W+1] ? '1 : mp3[AVG_W:9];
  assign idle_sat = (32'(idle_r) > PMASK32) ? PMASK32[PERIOD_BITS-1:0]
                                            : PERIOD_BITS'(32'(idle_r));
  assign elapsed  = t_ms_r - last_pulse_r;
  assign tmo      = elapsed > 32'(noflow_r);
  assign sat_hit  = prod_r <= DEN_W'(frm_pkg::RATE_SAT_LIMIT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == frm_pkg::OP_RATE) ? frm_pkg::S_REQ : frm_pkg::S_EDGE;
        end
      end
      frm_pkg::S_EDGE:  state_nxt = frm_pkg::S_STORE;
      frm_pkg::S_STORE: begin
        if (out_free) begin
          state_nxt = frm_pkg::S_IDLE;
        end
      end
      frm_pkg::S_REQ: begin
        state_nxt = (upd && ring_fill != '0) ? frm_pkg::S_MEAN : frm_pkg::S_TMO;
      end
      frm_pkg::S_MEAN: begin
        if (div_done) begin
          state_nxt = frm_pkg::S_AVG;
        end
      end
      frm_pkg::S_AVG:   state_nxt = frm_pkg::S_MUL;
      frm_pkg::S_MUL:   state_nxt = frm_pkg::S_SAT;
      frm_pkg::S_SAT:   state_nxt = sat_hit ? frm_pkg::S_TMO : frm_pkg::S_RATE;
      frm_pkg::S_RATE: begin
        if (div_done) begin
          state_nxt = frm_pkg::S_TMO;
        end
      end
      frm_pkg::S_TMO: begin
        if (out_free) begin
          state_nxt = frm_pkg::S_IDLE;
        end
      end
      default: state_nxt = frm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'({ring_sum, 8'd0}) << (NUM_W - MEAN_STEPS);
    div_den   = DEN_W'(ring_fill);
    div_steps = CNT_W'(MEAN_STEPS);
    ring_wr   = 1'b0;
    ring_clr  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      frm_pkg::S_REQ: begin
        div_start = upd && (ring_fill != '0);
      end
      frm_pkg::S_SAT: begin
        div_start = !sat_hit;
        div_num   = NUM_W'(frm_pkg::RATE_NUM) << (NUM_W - frm_pkg::RATE_NUM_W);
        div_den   = prod_r;
        div_steps = CNT_W'(frm_pkg::RATE_NUM_W);
      end
      frm_pkg::S_STORE: begin
        ring_wr  = out_free && sto_r;
        out_load = out_free;
      end
      frm_pkg::S_TMO: begin
        ring_clr = out_free && tmo;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= frm_pkg::S_IDLE;
      cal_r        <= frm_pkg::CAL_RST;
      minp_r       <= frm_pkg::MIN_PER_RST;
      noflow_r     <= frm_pkg::NO_FLOW_RST;
      idle_r       <= frm_pkg::IDLE_MAX_RST;
      prev_r       <= 1'b0;
      last_edge_r  <= '0;
      pending_r    <= '0;
      avg_r        <= '0;
      maxp_r       <= PERIOD_BITS'(frm_pkg::MAX_PER_RST);
      last_pulse_r <= '0;
      rate_r       <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          frm_pkg::REG_CAL:      cal_r    <= cfg_wdata;
          frm_pkg::REG_MIN_PER:  minp_r   <= cfg_wdata[19:0];
          frm_pkg::REG_NO_FLOW:  noflow_r <= cfg_wdata[15:0];
          frm_pkg::REG_IDLE_MAX: idle_r   <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      case (state_r)
        frm_pkg::S_EDGE: begin
          prev_r <= lvl_r;
          if (edge_acc) begin
            last_edge_r <= t_us_r;
          end
        end
        frm_pkg::S_STORE: begin
          if (ring_wr) begin
            pending_r <= pending_r + 32'd1;
          end
        end
        frm_pkg::S_REQ: begin
          if (upd) begin
            last_pulse_r <= t_ms_r;
            total_r      <= total_r + pending_r;
            pending_r    <= '0;
          end
        end
        frm_pkg::S_AVG: begin
          avg_r <= blend_p[frm_pkg::AVG_RECIP_SH +: AVG_W];
        end
        frm_pkg::S_SAT: begin
          if (sat_hit) begin
            rate_r <= '1;
            maxp_r <= mp_sat;
          end
        end
        frm_pkg::S_RATE: begin
          if (div_done) begin
            rate_r <= div_q[31:0];
            maxp_r <= mp_sat;
          end
        end
        frm_pkg::S_TMO: begin
          if (ring_clr) begin
            rate_r <= '0;
            maxp_r <= idle_sat;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == frm_pkg::S_IDLE && in_valid) begin
      lvl_r  <= in_pin_level;
      t_us_r <= in_time_us;
      t_ms_r <= in_time_ms;
    end
    if (state_r == frm_pkg::S_EDGE) begin
      acc_r <= edge_acc;
      sto_r <= edge_sto;
      dur_r <= dur[PERIOD_BITS-1:0];
    end
    if (state_r == frm_pkg::S_MEAN && div_done) begin
      blend_r <= avg_num;
    end
    if (state_r == frm_pkg::S_MUL) begin
      prod_r <= DEN_W'(avg_r) * DEN_W'(cal_r);
    end
    if (out_load) begin
      out_rate_r  <= ring_clr ? '0 : rate_r;
      out_total_r <= total_r;
      out_acc_r   <= (state_r == frm_pkg::S_STORE) && acc_r;
      out_sto_r   <= (state_r == frm_pkg::S_STORE) && sto_r;
      out_nf_r    <= ring_clr;
    end
  end

  frm_ring #(
    .RING_DEPTH  (RING_DEPTH),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (ring_wr),
    .clr    (ring_clr),
    .din    (dur_r),
    .sum_o  (ring_sum),
    .fill_o (ring_fill)
  );

  frm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quo_o   (div_q),
    .done_o  (div_done)
  );

  assign in_stall          = (state_r != frm_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_rate_upm      = out_rate_r;
  assign out_total_pulses  = out_total_r;
  assign out_edge_accepted = out_acc_r;
  assign out_period_stored = out_sto_r;
  assign out_no_flow       = out_nf_r;

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> (state_r == frm_pkg::S_EDGE || state_r == frm_pkg::S_REQ))
    else $error("accepted beat did not start a sequence");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == frm_pkg::S_MEAN || state_r == frm_pkg::S_RATE))
    else $error("divider finished outside a wait state");

  a_ring_wr_gate: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr |-> out_load && state_r == frm_pkg::S_STORE)
    else $error("ring written without result load");

  a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_sto_r || out_acc_r) && !(out_nf_r && out_acc_r))
    else $error("inconsistent result flags");

endmodule

[dv/flow_pulse_rate_meter_tb.sv]
`timescale 1ns / 1ps
module flow_pulse_rate_meter_tb;

  localparam int RING_DEPTH  = 24;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [31:0] rate_upm;
    logic [31:0] total_pulses;
    logic        edge_accepted;
    logic        period_stored;
    logic        no_flow;
  } meter_reading_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic        in_pin_level;
  logic [31:0] in_time_us;
  logic [31:0] in_time_ms;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_rate_upm;
  logic [31:0] out_total_pulses;
  logic        out_edge_accepted;
  logic        out_period_stored;
  logic        out_no_flow;

  flow_pulse_rate_meter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_pin_level     (in_pin_level),
    .in_time_us       (in_time_us),
    .in_time_ms       (in_time_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rate_upm     (out_rate_upm),
    .out_total_pulses (out_total_pulses),
    .out_edge_accepted(out_edge_accepted),
    .out_period_stored(out_period_stored),
    .out_no_flow      (out_no_flow)
  );

  // meter registers as the block should hold them
  logic [31:0] cal_r;
  logic [19:0] min_per_r;
  logic [15:0] no_flow_r;
  logic [19:0] idle_max_r;

  // meter state
  logic        prev_lvl;
  logic [31:0] last_edge;
  logic [31:0] pend_pulses;
  logic [19:0] period_slots [RING_DEPTH];
  logic [24:0] slot_sum;
  logic [4:0]  slot_idx;
  logic [5:0]  slot_fill;
  logic [27:0] avg_q8;
  logic [19:0] max_per;
  logic [31:0] last_ms;
  logic [31:0] rate_q16;
  logic [31:0] pulse_total;

  meter_reading_t readings_due [$];
  meter_reading_t want_r;

  int   errors;
  int   beats_sent;
  int   rate_reqs;
  int   readings_checked;
  int   timeouts_seen;
  int   periods_stored;
  int   rates_saturated;
  int   quiet_cycles;
  int   stall_left;
  logic idling_on;

  logic [63:0] flow_us;
  logic        pin_now;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h want 0x%08h at %0t", field, got, want, $time);
    errors++;
  endtask

  function automatic logic [31:0] upm_for_avg(input logic [27:0] a, input logic [31:0] c);
    logic [127:0] den;
    logic [127:0] quo;
    den = 128'(a) * 128'(c);
    if (den <= 128'(frm_pkg::RATE_SAT_LIMIT)) begin
      quo = 128'hFFFFFFFF;
    end else begin
      quo = (128'd60000000 << 40) / den;
    end
    return quo[31:0];
  endfunction

  task automatic clear_slots();
    for (int i = 0; i < RING_DEPTH; i++) period_slots[i] = '0;
    slot_sum  = '0;
    slot_idx  = '0;
    slot_fill = '0;
  endtask

  task automatic reset_meter();
    cal_r       = frm_pkg::CAL_RST;
    min_per_r   = frm_pkg::MIN_PER_RST;
    no_flow_r   = frm_pkg::NO_FLOW_RST;
    idle_max_r  = frm_pkg::IDLE_MAX_RST;
    prev_lvl    = 1'b0;
    last_edge   = '0;
    pend_pulses = '0;
    clear_slots();
    avg_q8      = '0;
    max_per     = frm_pkg::MAX_PER_RST[19:0];
    last_ms     = '0;
    rate_q16    = '0;
    pulse_total = '0;
  endtask

  // one accepted beat: update meter state and queue the reading it yields
  task automatic advance_meter(input logic op, input logic lvl, input logic [31:0] tus,
                               input logic [31:0] tms);
    logic [31:0]    dur;
    logic [63:0]    mean;
    logic [63:0]    blend;
    logic [29:0]    mp;
    meter_reading_t r;
    r = '0;
    if (op == frm_pkg::OP_PIN) begin
      if (lvl != prev_lvl) begin
        prev_lvl = lvl;
        if (lvl) begin
          dur = tus - last_edge;
          if (dur > 32'(min_per_r)) begin
            last_edge = tus;
            r.edge_accepted = 1'b1;
            if (dur < 32'(max_per)) begin
              r.period_stored = 1'b1;
              periods_stored++;
              pend_pulses++;
              slot_sum = slot_sum - 25'(period_slots[slot_idx]) + 25'(dur[19:0]);
              period_slots[slot_idx] = dur[19:0];
              slot_idx = (slot_idx == 5'(RING_DEPTH - 1)) ? 5'd0 : slot_idx + 5'd1;
              if (slot_fill < 6'(RING_DEPTH)) slot_fill++;
            end
          end
        end
      end
    end else begin
      rate_reqs++;
      if (pend_pulses != 0 && cal_r != 0) begin
        last_ms     = tms;
        pulse_total = pulse_total + pend_pulses;
        pend_pulses = '0;
        if (slot_fill != 0) begin
          mean   = (64'(slot_sum) << 8) / 64'(slot_fill);
          blend  = (64'd4 * mean + 64'(avg_q8) + 64'd2) / 64'(frm_pkg::AVG_DIV);
          avg_q8 = blend[27:0];
          rate_q16 = upm_for_avg(avg_q8, cal_r);
          if (rate_q16 == 32'hFFFFFFFF) rates_saturated++;
          mp = (30'(avg_q8) * 30'd3) >> 9;
          max_per = (mp > 30'hFFFFF) ? 20'hFFFFF : mp[19:0];
        end
      end
      if ((tms - last_ms) > 32'(no_flow_r)) begin
        r.no_flow = 1'b1;
        timeouts_seen++;
        rate_q16 = '0;
        max_per  = idle_max_r;
        clear_slots();
      end
    end
    r.rate_upm     = rate_q16;
    r.total_pulses = pulse_total;
    readings_due.push_back(r);
  endtask

  task automatic send_beat(input logic op, input logic lvl, input logic [31:0] tus,
                           input logic [31:0] tms);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 18);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_opcode    = op;
    in_pin_level = lvl;
    in_time_us   = tus;
    in_time_ms   = tms;
    do @(posedge clk); while (in_stall);
    advance_meter(op, lvl, tus, tms);
    beats_sent++;
  endtask

  task automatic drain_readings();
    @(negedge clk);
    in_valid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      frm_pkg::REG_CAL:      cal_r      = val;
      frm_pkg::REG_MIN_PER:  min_per_r  = val[19:0];
      frm_pkg::REG_NO_FLOW:  no_flow_r  = val[15:0];
      frm_pkg::REG_IDLE_MAX: idle_max_r = val[19:0];
      default: ;
    endcase
  endtask

  task automatic set_meter_regs(input logic [31:0] cal, input logic [31:0] min_per,
                                input logic [31:0] no_flow, input logic [31:0] idle_max);
    drain_readings();
    write_reg(frm_pkg::REG_CAL, cal);
    write_reg(frm_pkg::REG_MIN_PER, min_per);
    write_reg(frm_pkg::REG_NO_FLOW, no_flow);
    write_reg(frm_pkg::REG_IDLE_MAX, idle_max);
  endtask

  // pulse train with jittered periods, rate polls, no-flow gaps and some junk
  task automatic run_flow(input int n, input int pmin, input int pmax, input int req_pct);
    int          roll;
    logic [63:0] step;
    logic [31:0] ms_now;
    for (int k = 0; k < n; k++) begin
      roll   = $urandom_range(0, 99);
      ms_now = 32'(flow_us / 1000);
      if (roll < 7) begin
        send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom);
      end else if (roll < 7 + req_pct) begin
        send_beat(frm_pkg::OP_RATE, 1'($urandom_range(0, 1)), $urandom, ms_now);
      end else begin
        step = 64'($urandom_range(pmin, pmax) / 2);
        if ($urandom_range(0, 39) == 0) begin
          step = step + (64'(no_flow_r) + 64'($urandom_range(0, 3000))) * 1000;
        end
        flow_us = flow_us + step;
        pin_now = ~pin_now;
        send_beat(frm_pkg::OP_PIN, pin_now, flow_us[31:0], $urandom);
      end
    end
  endtask

  task automatic test_edge_rules();
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'd100, $urandom);     // too soon after reset edge
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'd200, $urandom);     // level unchanged
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'd300, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'd350, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'd500, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'd600, $urandom);     // exactly min period: rejected
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'd700, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'd1351, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'd2000, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'd51350, $urandom);   // just below max period
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'd60000, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'd101350, $urandom);  // at max period: not stored
    send_beat(frm_pkg::OP_RATE, 1'b0, $urandom, 32'd5);
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'hFFFFFF00, 32'hFFFFFFFF);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'hFFFFFF80, 32'h0);
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'hFFFFFFF0, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'h00000200, $urandom); // period across us wrap
    send_beat(frm_pkg::OP_RATE, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFF0);
    send_beat(frm_pkg::OP_RATE, 1'b0, 32'h0, 32'h00000010);   // elapsed across ms wrap
    send_beat(frm_pkg::OP_RATE, 1'b0, $urandom, 32'd3984);    // exactly the timeout
    send_beat(frm_pkg::OP_RATE, 1'b1, $urandom, 32'd3985);    // timeout
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'h0, 32'h0);
  endtask

  // pulses stranded by a timeout while the meter is disabled reach the total
  // later with an empty ring
  task automatic test_empty_ring_update();
    set_meter_regs(32'h0, 32'd250, 32'd4000, 32'd500000);
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'h10000000, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'h10000000 + 32'd1000, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'h10000000 + 32'd1500, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'h10000000 + 32'd2000, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b0, 32'h10000000 + 32'd2500, $urandom);
    send_beat(frm_pkg::OP_PIN, 1'b1, 32'h10000000 + 32'd3500, $urandom);
    send_beat(frm_pkg::OP_RATE, 1'b0, $urandom, 32'd100000);
    set_meter_regs(32'd65536, 32'd250, 32'd4000, 32'd500000);
    send_beat(frm_pkg::OP_RATE, 1'b0, $urandom, 32'd100010);
  endtask

  task automatic test_flow_phases();
    flow_us = 64'({22'($urandom_range(0, 1023)), 32'($urandom)});
    pin_now = 1'b0;
    set_meter_regs(32'd65536, 32'd250, 32'd4000, 32'd500000);
    run_flow(45, 300, 20000, 15);
    drain_readings();
    run_flow(45, 300, 20000, 15);
    set_meter_regs(32'hFFFFFFFF, 32'h0, 32'h0000FFFF, 32'hFFFFFFFF);
    run_flow(90, 50, 30000, 15);
    set_meter_regs(32'd1, 32'hFFFFFFFF, 32'h0, 32'h0);
    run_flow(50, 2000000, 2400000, 20);
    set_meter_regs(32'h0, 32'd100, 32'd500, 32'd300000);
    run_flow(60, 200, 8000, 15);
    set_meter_regs($urandom, 32'($urandom_range(0, 2000)), 32'($urandom_range(100, 5000)),
                   $urandom);
    run_flow(100, 300, 60000, 15);
  endtask

  task automatic test_no_idle_flow();
    set_meter_regs(32'h00018000, 32'd250, 32'd4000, 32'd500000);
    idling_on = 1'b0;
    run_flow(150, 500, 40000, 12);
  endtask

  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!idling_on) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if ($urandom_range(0, 99) < 10) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall  = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        flag_mismatch("beat with no reading due", out_rate_upm, 32'h0);
      end else begin
        want_r = readings_due.pop_front();
        readings_checked++;
        if (out_rate_upm !== want_r.rate_upm)
          flag_mismatch("rate_upm", out_rate_upm, want_r.rate_upm);
        if (out_total_pulses !== want_r.total_pulses)
          flag_mismatch("total_pulses", out_total_pulses, want_r.total_pulses);
        if (out_edge_accepted !== want_r.edge_accepted)
          flag_mismatch("edge_accepted", 32'(out_edge_accepted), 32'(want_r.edge_accepted));
        if (out_period_stored !== want_r.period_stored)
          flag_mismatch("period_stored", 32'(out_period_stored), 32'(want_r.period_stored));
        if (out_no_flow !== want_r.no_flow)
          flag_mismatch("no_flow", 32'(out_no_flow), 32'(want_r.no_flow));
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = frm_pkg::REG_CAL;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_opcode        = frm_pkg::OP_PIN;
    in_pin_level     = 1'b0;
    in_time_us       = '0;
    in_time_ms       = '0;
    idling_on        = 1'b1;
    errors           = 0;
    beats_sent       = 0;
    rate_reqs        = 0;
    readings_checked = 0;
    timeouts_seen    = 0;
    periods_stored   = 0;
    rates_saturated  = 0;
    reset_meter();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_rules();
    test_empty_ring_update();
    test_flow_phases();
    test_no_idle_flow();

    drain_readings();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (readings_due.size() != 0)
      flag_mismatch("readings never delivered", 32'(readings_due.size()), 32'h0);

    $display("Sent %0d beats (%0d rate requests), checked %0d readings.",
             beats_sent, rate_reqs, readings_checked);
    $display("Stored %0d periods, %0d no-flow timeouts, %0d saturated rates.",
             periods_stored, timeouts_seen, rates_saturated);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
